@@ rtl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared widths, command codes, octant codes and the pixel result type.
// ----------------------------------------------------------------------------
package lr_pkg;

	localparam int COORD_BITS = 9;
	localparam int COLOR_BITS = 24;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int DEC_BITS   = COORD_BITS + 4;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		OCT_SHALLOW_UP = 2'd0,
		OCT_STEEP_UP   = 2'd1,
		OCT_STEEP_DN   = 2'd2,
		OCT_SHALLOW_DN = 2'd3
	} oct_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   valid;
		logic   last;
	} pix_t;

endpackage

@@ rtl/lr_engine.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer engine
// Holds the Bresenham state, loads a new line on a start transfer and
// produces the current pixel while advancing the decision variable on a step.
// ----------------------------------------------------------------------------
module lr_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic           cmd,
	input  lr_pkg::coord_t start_x,
	input  lr_pkg::coord_t start_y,
	input  lr_pkg::coord_t end_x,
	input  lr_pkg::coord_t end_y,
	output lr_pkg::pix_t   pix
);
	import lr_pkg::*;

	coord_t                      cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic signed [DELTA_BITS-1:0] delta_y_q, delta_x_q;
	logic signed [DEC_BITS-1:0]   decision_q;
	oct_t                        octant_q;
	logic                        active_q;

	coord_t                      ax, ay, bx, by;
	logic signed [DELTA_BITS-1:0] da, db;
	logic signed [DEC_BITS-1:0]   da_w, db_w;
	oct_t                        ld_oct;
	logic signed [DEC_BITS-1:0]   ld_dec;
	logic                        ld_active;

	logic signed [DEC_BITS-1:0]   dx2, dy2;
	coord_t                      nx_x, nx_y;
	logic signed [DEC_BITS-1:0]   nx_dec;
	logic                        nx_active;

	function automatic logic more_pixels(oct_t oct, coord_t cx, coord_t cy,
			coord_t sx, coord_t sy);
		logic r;
		unique case (oct)
			OCT_STEEP_UP: r = cy < sy;
			OCT_STEEP_DN: r = cy > sy;
			default:      r = cx < sx;
		endcase
		return r;
	endfunction

	always_comb begin
		if (end_x < start_x) begin
			ax = end_x;
			ay = end_y;
			bx = start_x;
			by = start_y;
		end else begin
			ax = start_x;
			ay = start_y;
			bx = end_x;
			by = end_y;
		end
		da   = $signed({1'b0, by}) - $signed({1'b0, ay});
		db   = $signed({1'b0, bx}) - $signed({1'b0, ax});
		da_w = {{(DEC_BITS-DELTA_BITS){da[DELTA_BITS-1]}}, da};
		db_w = {{(DEC_BITS-DELTA_BITS){db[DELTA_BITS-1]}}, db};
		if (!da[DELTA_BITS-1]) begin
			if (db >= da) begin
				ld_oct = OCT_SHALLOW_UP;
				ld_dec = (da_w <<< 1) - db_w;
			end else begin
				ld_oct = OCT_STEEP_UP;
				ld_dec = da_w - (db_w <<< 1);
			end
		end else begin
			if (db >= -da) begin
				ld_oct = OCT_SHALLOW_DN;
				ld_dec = (da_w <<< 1) + db_w;
			end else begin
				ld_oct = OCT_STEEP_DN;
				ld_dec = da_w + (db_w <<< 1);
			end
		end
		ld_active = more_pixels(ld_oct, ax, ay, bx, by);
	end

	always_comb begin
		dx2    = {{(DEC_BITS-DELTA_BITS){delta_x_q[DELTA_BITS-1]}}, delta_x_q} <<< 1;
		dy2    = {{(DEC_BITS-DELTA_BITS){delta_y_q[DELTA_BITS-1]}}, delta_y_q} <<< 1;
		nx_x   = cur_x_q;
		nx_y   = cur_y_q;
		nx_dec = decision_q;
		unique case (octant_q)
			OCT_SHALLOW_UP: begin
				if (decision_q > 0) begin
					nx_y   = cur_y_q + 1'b1;
					nx_dec = decision_q - dx2 + dy2;
				end else begin
					nx_dec = decision_q + dy2;
				end
				nx_x = cur_x_q + 1'b1;
			end
			OCT_STEEP_UP: begin
				if (decision_q < 0) begin
					nx_x   = cur_x_q + 1'b1;
					nx_dec = decision_q + dy2 - dx2;
				end else begin
					nx_dec = decision_q - dx2;
				end
				nx_y = cur_y_q + 1'b1;
			end
			OCT_STEEP_DN: begin
				if (decision_q > 0) begin
					nx_x   = cur_x_q + 1'b1;
					nx_dec = decision_q + dy2 + dx2;
				end else begin
					nx_dec = decision_q + dx2;
				end
				nx_y = cur_y_q - 1'b1;
			end
			OCT_SHALLOW_DN: begin
				if (decision_q < 0) begin
					nx_y   = cur_y_q - 1'b1;
					nx_dec = decision_q + dx2 + dy2;
				end else begin
					nx_dec = decision_q + dy2;
				end
				nx_x = cur_x_q + 1'b1;
			end
		endcase
		nx_active = more_pixels(octant_q, nx_x, nx_y, stop_x_q, stop_y_q);
	end

	always_comb begin
		pix = '0;
		if (cmd == CMD_STEP && active_q) begin
			pix.x     = cur_x_q;
			pix.y     = cur_y_q;
			pix.valid = 1'b1;
			pix.last  = !nx_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			stop_x_q   <= '0;
			stop_y_q   <= '0;
			delta_y_q  <= '0;
			delta_x_q  <= '0;
			decision_q <= '0;
			octant_q   <= OCT_SHALLOW_UP;
			active_q   <= 1'b0;
		end else if (take) begin
			if (cmd == CMD_START) begin
				cur_x_q    <= ax;
				cur_y_q    <= ay;
				stop_x_q   <= bx;
				stop_y_q   <= by;
				delta_y_q  <= da;
				delta_x_q  <= db;
				decision_q <= ld_dec;
				octant_q   <= ld_oct;
				active_q   <= ld_active;
			end else if (active_q) begin
				cur_x_q    <= nx_x;
				cur_y_q    <= nx_y;
				decision_q <= nx_dec;
				active_q   <= nx_active;
			end
		end
	end

endmodule

@@ rtl/line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer core
// Bresenham line generator with a valid/ready command input and pixel output.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result in the next cycle: a start
// command returns an empty acknowledgement, a step command returns the next
// pixel of the line (or an empty result when no line is active). With the
// output side ready, one command is taken on every clock; the single output
// register holds a result while the output stalls and the input accepts
// again as soon as that register is taken. The far endpoint is not drawn.
// The color register is sampled when a step command is taken and should be
// written only while no command is outstanding.
module line_rasterizer_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  lr_pkg::color_t cfg_wdata,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           cmd,
	input  lr_pkg::coord_t start_x,
	input  lr_pkg::coord_t start_y,
	input  lr_pkg::coord_t end_x,
	input  lr_pkg::coord_t end_y,
	output logic           out_valid,
	input  logic           out_ready,
	output lr_pkg::coord_t pixel_x,
	output lr_pkg::coord_t pixel_y,
	output lr_pkg::color_t pixel_color,
	output logic           pixel_valid,
	output logic           last_pixel
);
	import lr_pkg::*;

	logic   take;
	pix_t   pix;
	color_t color_q;
	logic   out_valid_q;
	pix_t   res_q;
	color_t res_color_q;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	lr_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.cmd     (cmd),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.pix     (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q       <= pix;
			res_color_q <= pix.valid ? color_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = res_q.x;
	assign pixel_y     = res_q.y;
	assign pixel_color = res_color_q;
	assign pixel_valid = res_q.valid;
	assign last_pixel  = res_q.last;

endmodule

@@ rtl/lr_checker.sv @@
// ----------------------------------------------------------------------------
// Line rasterizer checker
// Port-level assertions for the line rasterizer core, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input lr_pkg::coord_t pixel_x,
	input lr_pkg::coord_t pixel_y,
	input lr_pkg::color_t pixel_color,
	input logic           pixel_valid,
	input logic           last_pixel
);
	import lr_pkg::*;

	// A stalled result keeps its contents until the transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_color) && $stable(pixel_valid) && $stable(last_pixel))
		else $error("result changed while stalled");

	// Every input transfer produces a result in the next cycle.
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after input transfer");

	// The input is open whenever the output register is free or draining.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked with free output");

	// Empty results carry all-zero fields.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0
			&& pixel_color == '0 && !last_pixel)
		else $error("empty result with nonzero fields");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line rasterizer core testbench
// Drives start and step commands through the valid/ready input, predicts each
// result with a Bresenham model of its own and checks every output transfer
// in order, under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------

module tb;
	import lr_pkg::*;

	typedef struct {
		coord_t x;
		coord_t y;
		color_t color;
		logic   valid;
		logic   last;
	} pixel_rec_t;

	class pixel_scoreboard;
		color_t                   color;
		coord_t                   pen_x, pen_y, far_x, far_y;
		int                       rise, run;
		int                       err_acc;
		oct_t                     octant;
		bit                       drawing;
		pixel_rec_t               pending_pixels[$];
		int                       mismatches, commands, starts, steps, checked, pixels, lasts;
		int                       octant_starts[4];

		function new();
			color = '0;
			pen_x = '0;
			pen_y = '0;
			far_x = '0;
			far_y = '0;
			rise = 0;
			run = 0;
			err_acc = 0;
			octant = OCT_SHALLOW_UP;
			drawing = 1'b0;
		endfunction

		function void set_color(color_t c);
			color = c;
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		function bit drawing_line();
			return drawing;
		endfunction

		function bit pixels_remain();
			case (octant)
				OCT_SHALLOW_UP, OCT_SHALLOW_DN: return pen_x < far_x;
				OCT_STEEP_UP: return pen_y < far_y;
				default: return pen_y > far_y;
			endcase
		endfunction

		function void take_command(cmd_t c, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
			pixel_rec_t want;
			coord_t     ax, ay, bx, by;
			int         a, b;
			want = '{x: '0, y: '0, color: '0, valid: 1'b0, last: 1'b0};
			commands++;
			if (c == CMD_START) begin
				starts++;
				ax = sx;
				ay = sy;
				bx = ex;
				by = ey;
				if (bx < ax) begin
					ax = ex;
					ay = ey;
					bx = sx;
					by = sy;
				end
				a = int'(by) - int'(ay);
				b = int'(bx) - int'(ax);
				pen_x = ax;
				pen_y = ay;
				far_x = bx;
				far_y = by;
				rise = a;
				run = b;
				if (a >= 0) begin
					if (b >= a) begin
						octant = OCT_SHALLOW_UP;
						err_acc = 2 * a - b;
					end else begin
						octant = OCT_STEEP_UP;
						err_acc = a - 2 * b;
					end
				end else begin
					if (b >= -a) begin
						octant = OCT_SHALLOW_DN;
						err_acc = 2 * a + b;
					end else begin
						octant = OCT_STEEP_DN;
						err_acc = a + 2 * b;
					end
				end
				octant_starts[octant]++;
				drawing = pixels_remain();
			end else begin
				steps++;
				if (drawing) begin
					want.x = pen_x;
					want.y = pen_y;
					want.color = color;
					want.valid = 1'b1;
					case (octant)
						OCT_SHALLOW_UP: begin
							if (err_acc > 0) begin
								pen_y = coord_t'(pen_y + 1);
								err_acc = err_acc - 2 * run;
							end
							pen_x = coord_t'(pen_x + 1);
							err_acc = err_acc + 2 * rise;
						end
						OCT_STEEP_UP: begin
							if (err_acc < 0) begin
								pen_x = coord_t'(pen_x + 1);
								err_acc = err_acc + 2 * rise;
							end
							pen_y = coord_t'(pen_y + 1);
							err_acc = err_acc - 2 * run;
						end
						OCT_STEEP_DN: begin
							if (err_acc > 0) begin
								pen_x = coord_t'(pen_x + 1);
								err_acc = err_acc + 2 * rise;
							end
							pen_y = coord_t'(pen_y - 1);
							err_acc = err_acc + 2 * run;
						end
						default: begin
							if (err_acc < 0) begin
								pen_y = coord_t'(pen_y - 1);
								err_acc = err_acc + 2 * run;
							end
							pen_x = coord_t'(pen_x + 1);
							err_acc = err_acc + 2 * rise;
						end
					endcase
					drawing = pixels_remain();
					want.last = !drawing;
				end
			end
			pending_pixels.push_back(want);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			if (mismatches <= 40)
				$display("MISMATCH %s: got 'h%0h, expected 'h%0h (result %0d)",
					what, got, want, checked);
		endtask

		task check_pixel(coord_t x, coord_t y, color_t col, logic v, logic l);
			pixel_rec_t want;
			if (pending_pixels.size() == 0) begin
				report("result with nothing outstanding", '0, '0);
				return;
			end
			want = pending_pixels.pop_front();
			checked++;
			if (x !== want.x)
				report("pixel_x", 32'(x), 32'(want.x));
			if (y !== want.y)
				report("pixel_y", 32'(y), 32'(want.y));
			if (col !== want.color)
				report("pixel_color", 32'(col), 32'(want.color));
			if (v !== want.valid)
				report("pixel_valid", 32'(v), 32'(want.valid));
			if (l !== want.last)
				report("last_pixel", 32'(l), 32'(want.last));
			if (want.valid)
				pixels++;
			if (want.last)
				lasts++;
		endtask
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_we = 1'b0;
	color_t cfg_wdata = '0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	cmd_t   in_cmd = CMD_START;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t end_x = '0;
	coord_t end_y = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	coord_t pixel_x, pixel_y;
	color_t pixel_color;
	logic   pixel_valid, last_pixel;

	pixel_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int sent = 0;

	line_rasterizer_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (in_cmd),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.pixel_valid (pixel_valid),
		.last_pixel  (last_pixel)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel);
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_command(cmd_t c, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_cmd <= c;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		sb.take_command(c, sx, sy, ex, ey);
		sent++;
	endtask

	task automatic step_through(int max_steps);
		int k;
		k = 0;
		while (sb.drawing_line() && k < max_steps) begin
			send_command(CMD_STEP, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
			k++;
		end
	endtask

	task automatic write_color(color_t c);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_color(c);
	endtask

	task automatic random_phase(int count);
		int     target, kind, ox, oy, len;
		coord_t sx, sy;
		target = sent + count;
		while (sent < target) begin
			kind = $urandom_range(99);
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			if (kind < 82) begin
				if (kind < 70) begin
					ox = $urandom_range(14);
					oy = $urandom_range(14);
				end else begin
					ox = $urandom_range(10);
					oy = ox;
				end
				if ($urandom_range(1))
					ox = -ox;
				if ($urandom_range(1))
					oy = -oy;
				send_command(CMD_START, sx, sy, coord_t'(int'(sx) + ox),
					coord_t'(int'(sy) + oy));
				len = ($urandom_range(99) < 10) ? $urandom_range(4) : 64;
				step_through(len);
				if ($urandom_range(9) == 0)
					step_through(1);
			end else if (kind < 92) begin
				send_command(CMD_START, sx, sy, coord_t'($urandom), coord_t'($urandom));
				step_through($urandom_range(1, 30));
			end else begin
				send_command(cmd_t'($urandom_range(1)), sx, sy,
					coord_t'($urandom), coord_t'($urandom));
			end
		end
	endtask

	initial begin
		int w;
		send_idle_pct = 11;
		recv_idle_pct = 56;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines under the reset color: idle step, empty line,
		// swapped full diagonal abandoned by a restart, horizontal line.
		step_through(0);
		send_command(CMD_STEP, 9'd511, 9'd511, 9'd511, 9'd511);
		send_command(CMD_START, 9'd0, 9'd0, 9'd0, 9'd0);
		send_command(CMD_STEP, 9'd0, 9'd0, 9'd0, 9'd0);
		send_command(CMD_START, 9'd511, 9'd511, 9'd0, 9'd0);
		step_through(2);
		send_command(CMD_START, 9'd5, 9'd10, 9'd8, 9'd10);
		step_through(64);
		write_color(24'hFFFFFF);

		// Vertical rise, swapped steep fall and swapped shallow fall diagonal.
		send_command(CMD_START, 9'd3, 9'd3, 9'd3, 9'd6);
		step_through(64);
		send_command(CMD_START, 9'd102, 9'd195, 9'd100, 9'd200);
		step_through(64);
		send_command(CMD_START, 9'd9, 9'd0, 9'd6, 9'd3);
		step_through(64);

		write_color(color_t'($urandom));
		random_phase(480);

		write_color(24'h000000);
		send_idle_pct = 56;
		recv_idle_pct = 11;
		random_phase(480);

		write_color(color_t'($urandom));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(240);
		hold_request = 300;
		random_phase(250);

		in_valid <= 1'b0;
		for (w = 0; w < 20000 && sb.pending() != 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("results never delivered", sb.pending(), 0);

		$display("Sent %0d commands: %0d line starts (octants %0d/%0d/%0d/%0d), %0d steps.",
			sb.commands, sb.starts, sb.octant_starts[0], sb.octant_starts[1],
			sb.octant_starts[2], sb.octant_starts[3], sb.steps);
		$display("Checked %0d results: %0d pixels, %0d line ends, %0d mismatches.",
			sb.checked, sb.pixels, sb.lasts, sb.mismatches);
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", sb.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
